// ===== src/sdtq_pkg.sv =====
package sdtq_pkg;

  localparam logic [31:0] FREQ_RESET = 32'd62500000;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [63:0] now_ticks;
    logic [31:0] timeout_seconds;
    logic [31:0] timer_id;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item_id;
    logic [63:0] item_deadline;
    logic        reprogram;
    logic [63:0] compare_tick;
    logic [4:0]  entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic        valid;
    logic        operation;
    logic [31:0] id;
    logic [63:0] deadline;
  } dl_beat_t;

endpackage

// ===== src/sdtq_deadline.sv =====
module sdtq_deadline (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  sdtq_pkg::in_beat_t beat_i,
  input  logic [31:0]       freq_i,
  output sdtq_pkg::dl_beat_t beat_o
);
  import sdtq_pkg::*;

  logic        s1_valid_q;
  logic        s1_op_q;
  logic [63:0] s1_now_q;
  logic [31:0] s1_id_q;
  logic [63:0] s1_prod_q;

  logic        s2_valid_q;
  logic        s2_op_q;
  logic [31:0] s2_id_q;
  logic [63:0] s2_deadline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q       <= beat_i.operation;
    s1_now_q      <= beat_i.now_ticks;
    s1_id_q       <= beat_i.timer_id;
    s1_prod_q     <= 64'(freq_i) * 64'(beat_i.timeout_seconds);
    s2_op_q       <= s1_op_q;
    s2_id_q       <= s1_id_q;
    s2_deadline_q <= s1_now_q + s1_prod_q;
  end

  assign beat_o.valid     = s2_valid_q;
  assign beat_o.operation = s2_op_q;
  assign beat_o.id        = s2_id_q;
  assign beat_o.deadline  = s2_deadline_q;

endmodule

// ===== src/sdtq_cell.sv =====
module sdtq_cell (
  input  logic               clk_i,
  input  sdtq_pkg::cell_ctl_t ctl_i,
  input  sdtq_pkg::entry_t    new_i,
  input  logic               occupied_i,
  input  logic               left_keep_i,
  input  sdtq_pkg::entry_t    left_i,
  input  sdtq_pkg::entry_t    right_i,
  output logic               keep_o,
  output sdtq_pkg::entry_t    entry_o
);
  import sdtq_pkg::*;

  entry_t entry_d, entry_q;

  assign keep_o  = occupied_i && (entry_q.deadline <= new_i.deadline);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? new_i : left_i;
      end
    end else if (ctl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== src/sorted_deadline_timer_queue.sv =====
// Holds up to QUEUE_DEPTH timers in deadline order in a row of cells, one
// timer per cell. A beat is taken whenever start is high and busy is low;
// busy stays low, so one insert or pop may be issued in every cycle. Each
// beat yields exactly one result, strobed by result_valid_o for one cycle.
// The frequency multiplication happens in the cycle that ends with the
// taking edge, the deadline addition in the next cycle, and the compare and
// shift in the cells in the cycle after that. Results cannot be held off,
// so the receiver must take every strobe as it comes. Beats are processed
// strictly in order.
module sorted_deadline_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sdtq_pkg::in_beat_t  item_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  output logic                result_valid_o,
  output sdtq_pkg::out_beat_t result_o
);
  import sdtq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]     freq_q;
  logic [CntW-1:0] count_d, count_q;
  logic [63:0]     compare_d, compare_q;
  logic            rvalid_q;
  out_beat_t       result_d, result_q;

  dl_beat_t  dl_beat;
  cell_ctl_t ctl;
  entry_t    new_entry;
  logic      full, empty, accept;

  logic   keep [QUEUE_DEPTH];
  entry_t cells [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RESET;
    end else if (cfg_we_i) begin
      freq_q <= cfg_wdata_i;
    end
  end

  sdtq_deadline u_deadline (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .beat_i  (item_i),
    .freq_i  (freq_q),
    .beat_o  (dl_beat)
  );

  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  assign new_entry.deadline = dl_beat.deadline;
  assign new_entry.id       = dl_beat.id;
  assign ctl.insert = dl_beat.valid && (dl_beat.operation == OP_INSERT) && !full;
  assign ctl.pop    = dl_beat.valid && (dl_beat.operation == OP_POP) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_keep;
    entry_t left_entry, right_entry;

    if (i == 0) begin : g_first
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_mid
      assign left_keep  = keep[i-1];
      assign left_entry = cells[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = cells[i];
    end else begin : g_inner
      assign right_entry = cells[i+1];
    end

    sdtq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .new_i       (new_entry),
      .occupied_i  (CntW'(i) < count_q),
      .left_keep_i (left_keep),
      .left_i      (left_entry),
      .right_i     (right_entry),
      .keep_o      (keep[i]),
      .entry_o     (cells[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    compare_d = compare_q;
    result_d.status        = STATUS_DONE;
    result_d.item_id       = dl_beat.id;
    result_d.item_deadline = dl_beat.deadline;
    result_d.reprogram     = 1'b0;
    if (dl_beat.operation == OP_POP) begin
      if (empty) begin
        result_d.status        = STATUS_EMPTY;
        result_d.item_id       = '0;
        result_d.item_deadline = '0;
      end else begin
        result_d.item_id       = cells[0].id;
        result_d.item_deadline = cells[0].deadline;
        count_d                = count_q - 1'b1;
      end
    end else begin
      if (full) begin
        result_d.status = STATUS_FULL;
      end else begin
        count_d = count_q + 1'b1;
        if (dl_beat.deadline < compare_q) begin
          compare_d          = dl_beat.deadline;
          result_d.reprogram = 1'b1;
        end
      end
    end
    result_d.compare_tick = compare_d;
    result_d.entry_count  = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      compare_q <= '1;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= dl_beat.valid;
      if (dl_beat.valid) begin
        count_q   <= count_d;
        compare_q <= compare_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_beat.valid) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = result_q;

endmodule

// ===== dv/sorted_deadline_timer_queue_test.sv =====
`timescale 1ns / 100ps

module sorted_deadline_timer_queue_test;
  import sdtq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 60;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  in_beat_t    request_beat = '0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  out_beat_t   result_o;

  logic [63:0] queued_deadline [QUEUE_DEPTH];
  logic [31:0] queued_id [QUEUE_DEPTH];
  int          queued_total  = 0;
  logic [63:0] compare_model = '1;
  logic [31:0] freq_model    = FREQ_RESET;

  out_beat_t   pending_results [$];
  out_beat_t   want;
  int          mismatches  = 0;
  int          cycle_count = 0;
  bit          no_idle     = 1'b0;

  sorted_deadline_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (request_beat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_beat_t predict_timer_step(in_beat_t b);
    out_beat_t   r;
    logic [63:0] dl;
    int          pos;
    r = '0;
    if (b.operation == OP_POP) begin
      if (queued_total == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.status        = STATUS_DONE;
        r.item_id       = queued_id[0];
        r.item_deadline = queued_deadline[0];
        for (int k = 0; k < queued_total - 1; k++) begin
          queued_deadline[k] = queued_deadline[k + 1];
          queued_id[k]       = queued_id[k + 1];
        end
        queued_total--;
      end
    end else begin
      dl = b.now_ticks + ({32'd0, freq_model} * {32'd0, b.timeout_seconds});
      r.item_id       = b.timer_id;
      r.item_deadline = dl;
      if (queued_total >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        r.status = STATUS_DONE;
        pos = 0;
        while (pos < queued_total && queued_deadline[pos] <= dl) pos++;
        for (int k = queued_total; k > pos; k--) begin
          queued_deadline[k] = queued_deadline[k - 1];
          queued_id[k]       = queued_id[k - 1];
        end
        queued_deadline[pos] = dl;
        queued_id[pos]       = b.timer_id;
        queued_total++;
        if (dl < compare_model) begin
          compare_model = dl;
          r.reprogram   = 1'b1;
        end
      end
    end
    r.compare_tick = compare_model;
    r.entry_count  = 5'(queued_total);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result beat expected none actual %h", $time, result_o);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(result_o.status));
        check_field("item_id", 64'(want.item_id), 64'(result_o.item_id));
        check_field("item_deadline", want.item_deadline, result_o.item_deadline);
        check_field("reprogram", 64'(want.reprogram), 64'(result_o.reprogram));
        check_field("compare_tick", want.compare_tick, result_o.compare_tick);
        check_field("entry_count", 64'(want.entry_count),
                    64'(result_o.entry_count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The beat is taken at the first edge at which busy is low; start stays high
  // into the next call when no gap follows.
  task automatic issue_request(in_beat_t b);
    int r;
    int gap;
    start        <= 1'b1;
    request_beat <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_timer_step(b));
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_frequency(logic [31:0] freq);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= freq;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    freq_model = freq;
  endtask

  task automatic issue_insert(logic [63:0] now, logic [31:0] secs, logic [31:0] id);
    in_beat_t b;
    b.operation       = OP_INSERT;
    b.now_ticks       = now;
    b.timeout_seconds = secs;
    b.timer_id        = id;
    issue_request(b);
  endtask

  task automatic issue_pop();
    in_beat_t b;
    b.operation       = OP_POP;
    b.now_ticks       = {$urandom, $urandom};
    b.timeout_seconds = $urandom;
    b.timer_id        = $urandom;
    issue_request(b);
  endtask

  task automatic run_random_traffic(int count);
    int          left;
    int          seg;
    int          pop_pct;
    int          r;
    logic [63:0] base_now;
    logic [63:0] now;
    logic [31:0] secs;
    left = count;
    while (left > 0) begin
      seg = $urandom_range(4, 40);
      r   = $urandom_range(0, 2);
      pop_pct  = (r == 0) ? 15 : (r == 1) ? 85 : 50;
      base_now = {$urandom, $urandom};
      while (seg > 0 && left > 0) begin
        if ($urandom_range(1, 100) <= pop_pct) begin
          issue_pop();
        end else begin
          case ($urandom_range(0, 3))
            0:       now = base_now;
            3:       now = {32'hFFFF_FFFF, $urandom};
            default: now = {$urandom, $urandom};
          endcase
          r = $urandom_range(0, 9);
          if (r < 4) secs = $urandom_range(0, 3);
          else if (r < 8) secs = $urandom;
          else secs = 32'hFFFF_FFFF;
          issue_insert(now, secs, $urandom);
        end
        seg--;
        left--;
      end
    end
  endtask

  task automatic test_directed_cases();
    issue_pop();
    issue_insert(64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_insert(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd0);
    issue_insert(64'd1000, 32'd0, 32'd1);
    issue_insert(64'd1000, 32'd0, 32'd2);
    issue_insert(64'd2000, 32'd0, 32'd3);
    for (int i = 0; i < QUEUE_DEPTH - 5; i++) begin
      issue_insert(64'd500 + 64'(i) * 64'h0123_4567_89AB_CDEF, 32'(i), 32'hA000 + 32'(i));
    end
    issue_insert({$urandom, $urandom}, $urandom, $urandom);
    repeat (3) issue_pop();
  endtask

  task automatic test_frequency_extremes();
    set_frequency(32'd1);
    run_random_traffic(150);
    set_frequency(32'hFFFF_FFFF);
    run_random_traffic(150);
    set_frequency(32'd0);
    run_random_traffic(120);
    set_frequency(FREQ_RESET);
    run_random_traffic(100);
  endtask

  task automatic test_random_frequencies();
    repeat (3) begin
      set_frequency($urandom);
      run_random_traffic(110);
    end
  endtask

  task automatic test_back_to_back();
    set_frequency($urandom_range(1, 1000));
    no_idle = 1'b1;
    run_random_traffic(150);
    no_idle = 1'b0;
  endtask

  task automatic test_zero_deadline();
    issue_insert(64'd0, 32'd0, $urandom);
    repeat (QUEUE_DEPTH + 2) issue_pop();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_frequency_extremes();
    test_random_frequencies();
    test_back_to_back();
    test_zero_deadline();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
